>>> hdl/frame_recycled_chunk_allocator_top_macros.svh
// assertion macros for the frame recycled chunk allocator checker
// expects clk_i and rst_ni in the scope of each use
`ifndef FRAME_RECYCLED_CHUNK_ALLOCATOR_TOP_MACROS_SVH
`define FRAME_RECYCLED_CHUNK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FRCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/frca_pkg.sv
// shared constants and command/status types of the frame recycled chunk allocator
// no dependencies
package frca_pkg;

  localparam int unsigned MAX_CHUNKS_DEF = 8;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ALIGN_W   = 5;
  localparam int unsigned ROUNDS_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_IDX_W = 3;

  localparam logic [DATA_W-1:0]   DEFAULT_MIN_CHUNK = 32'd2097152;
  localparam logic [ALIGN_W-1:0]  RESET_ALIGN_LOG2  = 5'd8;
  localparam logic [ALIGN_W-1:0]  MAX_ALIGN_LOG2    = 5'd16;
  localparam logic [ROUNDS_W-1:0] RESET_ROUNDS      = 6'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_ROUNDS = 2'd2;

  localparam logic ACTION_ALLOC   = 1'b0;
  localparam logic ACTION_ADVANCE = 1'b1;

  typedef struct packed {
    logic advance;
    logic begin_req;
    logic read;
    logic eval;
    logic fit_chk;
    logic step;
    logic emit_full;
    logic open_max;
    logic commit;
  } frca_cmd_t;

  typedef struct packed {
    logic last_ok;
    logic any_open;
    logic more;
    logic fit;
    logic full;
  } frca_sts_t;

endpackage

>>> hdl/frame_recycled_chunk_allocator_top.sv
// Per-frame bump allocator over a table of up to MAX_CHUNKS chunks, with idle-chunk recycling.
// A frame advance is accepted when start is high and busy is low, and done_o pulses in the next
// cycle. An allocation request holds busy high while it visits chunks, each in turn through
// table read, age and alignment, and fit test, and while it opens a chunk. Every item gives
// exactly one result, shown for a single cycle with done_o high; there is no back-pressure
// on results, so the receiver must take each one as it appears. The chunk table needs no
// clearing after reset. Configuration writes belong in idle cycles (busy low, no done_o).
// depends on frca_pkg, frca_ctrl, frca_dp
module frame_recycled_chunk_allocator_top import frca_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action_i,
  input  logic [DATA_W-1:0]    request_size_i,
  output logic                 done_o,
  output logic                 status_o,
  output logic [OUT_IDX_W-1:0] chunk_index_o,
  output logic [DATA_W-1:0]    byte_offset_o,
  output logic                 opened_chunk_o,
  output logic [DATA_W-1:0]    opened_capacity_o
);

  frca_cmd_t cmd;
  frca_sts_t sts;

  frca_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  frca_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .request_size_i    (request_size_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .done_o            (done_o),
    .status_o          (status_o),
    .chunk_index_o     (chunk_index_o),
    .byte_offset_o     (byte_offset_o),
    .opened_chunk_o    (opened_chunk_o),
    .opened_capacity_o (opened_capacity_o)
  );

endmodule

>>> hdl/frca_ctrl.sv
// controller state machine of the frame recycled chunk allocator
// depends on frca_pkg
module frca_ctrl import frca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      action_i,
  input  frca_sts_t sts_i,
  output frca_cmd_t cmd_o,
  output logic      busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FIT,
    ST_OPEN_MAX,
    ST_OPEN_CAP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACTION_ADVANCE) begin
            cmd_o.advance = 1'b1;
          end else begin
            cmd_o.begin_req = 1'b1;
            state_d = (sts_i.last_ok || sts_i.any_open) ? ST_READ : ST_OPEN_MAX;
          end
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_FIT;
      end
      ST_FIT: begin
        cmd_o.fit_chk = 1'b1;
        if (sts_i.fit) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.more) begin
            state_d = ST_READ;
          end else if (sts_i.full) begin
            cmd_o.emit_full = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_OPEN_MAX;
          end
        end
      end
      ST_OPEN_MAX: begin
        cmd_o.open_max = 1'b1;
        state_d = ST_OPEN_CAP;
      end
      ST_OPEN_CAP: begin
        cmd_o.commit = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> hdl/frca_dp.sv
// datapath of the frame recycled chunk allocator: config, chunk table, fit test, results
// depends on frca_pkg
module frca_dp import frca_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  logic [DATA_W-1:0]    request_size_i,
  input  frca_cmd_t            cmd_i,
  output frca_sts_t            sts_o,
  output logic                 done_o,
  output logic                 status_o,
  output logic [OUT_IDX_W-1:0] chunk_index_o,
  output logic [DATA_W-1:0]    byte_offset_o,
  output logic                 opened_chunk_o,
  output logic [DATA_W-1:0]    opened_capacity_o
);

  localparam int unsigned IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);

  // configuration, stored already clamped
  logic [DATA_W-1:0]   min_q;
  logic [ALIGN_W-1:0]  lg_q;
  logic [ROUNDS_W-1:0] rounds_q;

  logic [DATA_W-1:0] fc_q;
  logic [CNT_W-1:0]  open_q;
  logic [IDX_W-1:0]  last_q;
  logic              last_valid_q;
  logic [IDX_W-1:0]  cur_q;
  logic              from_last_q;

  logic [DATA_W-1:0] size_q;
  logic [DATA_W:0]   start_q;
  logic              recycle_q;
  logic [DATA_W-1:0] max_q;

  logic [DATA_W-1:0] cap_mem   [MAX_CHUNKS];
  logic [DATA_W-1:0] used_mem  [MAX_CHUNKS];
  logic [DATA_W-1:0] frame_mem [MAX_CHUNKS];
  logic [DATA_W-1:0] cap_rd_q, used_rd_q, frame_rd_q;

  logic              done_q, status_q, opened_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] off_q, opcap_q;

  logic [DATA_W:0]    mask;
  logic [DATA_W:0]    aligned_used;
  logic [DATA_W-1:0]  age;
  logic               recycle;
  logic [DATA_W+1:0]  end_sum;
  logic               fit;
  logic [DATA_W:0]    cap_sum;
  logic [DATA_W-1:0]  new_cap;
  logic [IDX_W-1:0]   wr_addr;
  logic               used_we, frame_we;
  logic [DATA_W-1:0]  used_wdata;
  logic [IDX_W+2:0]   idx_ext;
  logic               last_ok;

  assign mask         = ((DATA_W+1)'(1) << lg_q) - (DATA_W+1)'(1);
  assign aligned_used = ({1'b0, used_rd_q} + mask) & ~mask;
  assign age          = fc_q - frame_rd_q;
  assign recycle      = (age >= DATA_W'(rounds_q));
  assign end_sum      = {1'b0, start_q} + {2'b00, size_q};
  assign fit          = (end_sum <= {2'b00, cap_rd_q});
  assign cap_sum      = ({1'b0, max_q} + mask) & ~mask;
  assign new_cap      = cap_sum[DATA_W] ? '1 : cap_sum[DATA_W-1:0];

  assign last_ok = last_valid_q && (CNT_W'(last_q) < open_q);

  assign sts_o.last_ok  = last_ok;
  assign sts_o.any_open = (open_q != '0);
  assign sts_o.more     = from_last_q ? (open_q != '0) : ((CNT_W'(cur_q) + CNT_W'(1)) < open_q);
  assign sts_o.fit      = fit;
  assign sts_o.full     = (open_q == CNT_W'(MAX_CHUNKS));

  // chunk table write port
  assign wr_addr    = cmd_i.commit ? open_q[IDX_W-1:0] : cur_q;
  assign used_we    = cmd_i.commit | (cmd_i.fit_chk & (fit | recycle_q));
  assign frame_we   = cmd_i.commit | (cmd_i.fit_chk & recycle_q);
  assign used_wdata = cmd_i.commit ? size_q : (fit ? end_sum[DATA_W-1:0] : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      cap_mem[wr_addr] <= new_cap;
    end
    if (used_we) begin
      used_mem[wr_addr] <= used_wdata;
    end
    if (frame_we) begin
      frame_mem[wr_addr] <= fc_q;
    end
    if (cmd_i.read) begin
      cap_rd_q   <= cap_mem[cur_q];
      used_rd_q  <= used_mem[cur_q];
      frame_rd_q <= frame_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= DEFAULT_MIN_CHUNK;
      lg_q         <= RESET_ALIGN_LOG2;
      rounds_q     <= RESET_ROUNDS;
      fc_q         <= '0;
      open_q       <= '0;
      last_q       <= '0;
      last_valid_q <= 1'b0;
      cur_q        <= '0;
      from_last_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_CHUNK: begin
            min_q <= (cfg_wdata_i == '0) ? DEFAULT_MIN_CHUNK : cfg_wdata_i;
          end
          CFG_ALIGN_LOG2: begin
            lg_q <= (cfg_wdata_i[ALIGN_W-1:0] > MAX_ALIGN_LOG2) ?
                    MAX_ALIGN_LOG2 : cfg_wdata_i[ALIGN_W-1:0];
          end
          CFG_REUSE_ROUNDS: begin
            rounds_q <= (cfg_wdata_i[ROUNDS_W-1:0] == '0) ?
                        ROUNDS_W'(1) : cfg_wdata_i[ROUNDS_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.advance) begin
        fc_q <= fc_q + DATA_W'(1);
      end
      if (cmd_i.begin_req) begin
        cur_q       <= last_ok ? last_q : '0;
        from_last_q <= last_ok;
      end
      if (cmd_i.step) begin
        if (from_last_q) begin
          cur_q       <= '0;
          from_last_q <= 1'b0;
        end else begin
          cur_q <= cur_q + IDX_W'(1);
        end
      end
      if (cmd_i.fit_chk && fit) begin
        last_q       <= cur_q;
        last_valid_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        open_q       <= open_q + CNT_W'(1);
        last_q       <= open_q[IDX_W-1:0];
        last_valid_q <= 1'b1;
      end
      done_q <= cmd_i.advance | cmd_i.emit_full | (cmd_i.fit_chk & fit) | cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_req) begin
      size_q <= request_size_i;
    end
    if (cmd_i.eval) begin
      start_q   <= recycle ? '0 : aligned_used;
      recycle_q <= recycle;
    end
    if (cmd_i.open_max) begin
      max_q <= (size_q > min_q) ? size_q : min_q;
    end
    if (cmd_i.advance || cmd_i.emit_full) begin
      status_q <= cmd_i.emit_full;
      idx_q    <= '0;
      off_q    <= '0;
      opened_q <= 1'b0;
      opcap_q  <= '0;
    end else if (cmd_i.fit_chk && fit) begin
      status_q <= 1'b0;
      idx_q    <= cur_q;
      off_q    <= start_q[DATA_W-1:0];
      opened_q <= 1'b0;
      opcap_q  <= '0;
    end else if (cmd_i.commit) begin
      status_q <= 1'b0;
      idx_q    <= open_q[IDX_W-1:0];
      off_q    <= '0;
      opened_q <= 1'b1;
      opcap_q  <= new_cap;
    end
  end

  assign idx_ext = {3'b000, idx_q};

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign chunk_index_o     = idx_ext[OUT_IDX_W-1:0];
  assign byte_offset_o     = off_q;
  assign opened_chunk_o    = opened_q;
  assign opened_capacity_o = opcap_q;

endmodule

>>> hdl/frca_chk.sv
// port-level assertion checker for the frame recycled chunk allocator, bound to the top level
// depends on frca_pkg and frame_recycled_chunk_allocator_top_macros.svh
`include "frame_recycled_chunk_allocator_top_macros.svh"

module frca_chk import frca_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 action_i,
  input logic                 done_o,
  input logic                 status_o,
  input logic [OUT_IDX_W-1:0] chunk_index_o,
  input logic [DATA_W-1:0]    byte_offset_o,
  input logic                 opened_chunk_o,
  input logic [DATA_W-1:0]    opened_capacity_o
);

  `FRCA_ASSERT_NEXT(a_advance_done, start && !busy && (action_i == ACTION_ADVANCE), done_o && !busy, "frame advance did not finish in one cycle")
  `FRCA_ASSERT_NEXT(a_request_busy, start && !busy && (action_i == ACTION_ALLOC), busy && !done_o, "request did not hold busy")
  `FRCA_ASSERT_NOW(a_full_zero, done_o && status_o, (chunk_index_o == '0) && (byte_offset_o == '0) && !opened_chunk_o && (opened_capacity_o == '0), "full status with nonzero fields")
  `FRCA_ASSERT_NOW(a_open_fields, done_o && opened_chunk_o, !status_o && (byte_offset_o == '0) && (opened_capacity_o != '0), "bad opened chunk fields")

endmodule

bind frame_recycled_chunk_allocator_top frca_chk u_frca_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .action_i          (action_i),
  .done_o            (done_o),
  .status_o          (status_o),
  .chunk_index_o     (chunk_index_o),
  .byte_offset_o     (byte_offset_o),
  .opened_chunk_o    (opened_chunk_o),
  .opened_capacity_o (opened_capacity_o)
);

>>> dv/frame_recycled_chunk_allocator_top_test.sv
// self-checking testbench for frame_recycled_chunk_allocator_top: a chunk-table ledger class
// tracks the expected grant for every accepted item, plain tasks drive commands and registers
// depends on frca_pkg and frame_recycled_chunk_allocator_top
module frame_recycled_chunk_allocator_top_test;
  import frca_pkg::*;

  localparam int unsigned CHUNKS = MAX_CHUNKS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 3 * (CHUNKS + 1) + 10;

  typedef struct packed {
    logic                 status;
    logic [OUT_IDX_W-1:0] chunk_index;
    logic [DATA_W-1:0]    byte_offset;
    logic                 opened_chunk;
    logic [DATA_W-1:0]    opened_capacity;
  } grant_t;

  class chunk_ledger;
    logic [DATA_W-1:0]   min_chunk = DEFAULT_MIN_CHUNK;
    logic [ALIGN_W-1:0]  align_log2 = RESET_ALIGN_LOG2;
    logic [ROUNDS_W-1:0] reuse_rounds = RESET_ROUNDS;

    logic [DATA_W-1:0] cap [CHUNKS];
    logic [DATA_W-1:0] used [CHUNKS];
    logic [DATA_W-1:0] frm [CHUNKS];
    int unsigned       open_cnt = 0;
    int unsigned       last_idx = 0;
    bit                last_ok = 0;
    logic [DATA_W-1:0] frame_cnt = '0;

    grant_t grants [$];
    int unsigned errors = 0;
    int unsigned n_alloc = 0, n_adv = 0, n_full = 0, n_opened = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        CFG_MIN_CHUNK:    min_chunk = d;
        CFG_ALIGN_LOG2:   align_log2 = d[ALIGN_W-1:0];
        CFG_REUSE_ROUNDS: reuse_rounds = d[ROUNDS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] align_up(logic [63:0] v, int unsigned lg);
      logic [63:0] a;
      a = 64'd1 << lg;
      return (v + a - 64'd1) & ~(a - 64'd1);
    endfunction

    // recycle an idle chunk, then try a bump allocation in it
    function bit try_fit(int unsigned i, logic [DATA_W-1:0] sz, int unsigned lg,
                         logic [DATA_W-1:0] rnd, output logic [DATA_W-1:0] off);
      logic [DATA_W-1:0] age;
      logic [63:0]       st;
      off = '0;
      age = frame_cnt - frm[i];
      if (age >= rnd) begin
        used[i] = '0;
        frm[i] = frame_cnt;
      end
      st = align_up({32'd0, used[i]}, lg);
      if (st + {32'd0, sz} > {32'd0, cap[i]}) return 0;
      off = st[31:0];
      used[i] = st[31:0] + sz;
      return 1;
    endfunction

    function void record_item(logic act, logic [DATA_W-1:0] sz);
      grant_t            g;
      int unsigned       lg, k, pick;
      logic [DATA_W-1:0] rnd, mn, off;
      logic [63:0]       c;
      bit                hit;
      g = '0;
      lg = (align_log2 > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : align_log2;
      rnd = (reuse_rounds == 0) ? 32'd1 : 32'(reuse_rounds);
      mn = (min_chunk == 0) ? DEFAULT_MIN_CHUNK : min_chunk;
      if (act == ACTION_ADVANCE) begin
        frame_cnt = frame_cnt + 32'd1;
        n_adv++;
        grants.push_back(g);
        return;
      end
      n_alloc++;
      hit = 0;
      pick = 0;
      off = '0;
      if (last_ok && last_idx < open_cnt) begin
        if (try_fit(last_idx, sz, lg, rnd, off)) begin
          hit = 1;
          pick = last_idx;
        end
      end
      for (k = 0; !hit && k < open_cnt; k++) begin
        if (try_fit(k, sz, lg, rnd, off)) begin
          hit = 1;
          pick = k;
        end
      end
      if (hit) begin
        last_idx = pick;
        last_ok = 1;
        g.chunk_index = pick[OUT_IDX_W-1:0];
        g.byte_offset = off;
      end else if (open_cnt >= CHUNKS) begin
        g.status = 1'b1;
        n_full++;
      end else begin
        c = align_up({32'd0, (sz > mn) ? sz : mn}, lg);
        if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
        cap[open_cnt] = c[31:0];
        used[open_cnt] = sz;
        frm[open_cnt] = frame_cnt;
        g.chunk_index = open_cnt[OUT_IDX_W-1:0];
        g.opened_chunk = 1'b1;
        g.opened_capacity = c[31:0];
        last_idx = open_cnt;
        last_ok = 1;
        open_cnt++;
        n_opened++;
      end
      grants.push_back(g);
    endfunction

    function void match_result(grant_t got);
      grant_t exp_g;
      if (grants.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      exp_g = grants.pop_front();
      if (got.status !== exp_g.status) begin
        $error("status: expected %0d, got %0d", exp_g.status, got.status);
        errors++;
      end
      if (got.chunk_index !== exp_g.chunk_index) begin
        $error("chunk_index: expected %0d, got %0d", exp_g.chunk_index, got.chunk_index);
        errors++;
      end
      if (got.byte_offset !== exp_g.byte_offset) begin
        $error("byte_offset: expected %h, got %h", exp_g.byte_offset, got.byte_offset);
        errors++;
      end
      if (got.opened_chunk !== exp_g.opened_chunk) begin
        $error("opened_chunk: expected %0d, got %0d", exp_g.opened_chunk, got.opened_chunk);
        errors++;
      end
      if (got.opened_capacity !== exp_g.opened_capacity) begin
        $error("opened_capacity: expected %h, got %h", exp_g.opened_capacity,
               got.opened_capacity);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return grants.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic                 action_i;
  logic [DATA_W-1:0]    request_size_i;
  logic                 done_o;
  logic                 status_o;
  logic [OUT_IDX_W-1:0] chunk_index_o;
  logic [DATA_W-1:0]    byte_offset_o;
  logic                 opened_chunk_o;
  logic [DATA_W-1:0]    opened_capacity_o;

  chunk_ledger ledger = new();
  int unsigned n_settings = 0;
  int unsigned n_sent = 0;

  frame_recycled_chunk_allocator_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .request_size_i    (request_size_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .chunk_index_o     (chunk_index_o),
    .byte_offset_o     (byte_offset_o),
    .opened_chunk_o    (opened_chunk_o),
    .opened_capacity_o (opened_capacity_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      ledger.match_result({status_o, chunk_index_o, byte_offset_o, opened_chunk_o,
                           opened_capacity_o});
    end
  end

  // present one item and hold it until accepted
  task automatic issue(logic act, logic [DATA_W-1:0] sz);
    start <= 1'b1;
    action_i <= act;
    request_size_i <= sz;
    do @(posedge clk_i); while (busy);
    ledger.record_item(act, sz);
    n_sent++;
  endtask

  task automatic hold_off(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait until every grant is back and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    ledger.set_reg(idx, d);
  endtask

  task automatic program_regs(logic [DATA_W-1:0] mn, logic [DATA_W-1:0] al,
                              logic [DATA_W-1:0] rr, bit touch_spare);
    write_one(CFG_MIN_CHUNK, mn);
    write_one(CFG_ALIGN_LOG2, al);
    write_one(CFG_REUSE_ROUNDS, rr);
    if (touch_spare) write_one(CFG_SPARE_IDX, $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:             return '0;
      1:             return 32'hFFFF_FFFF;
      2, 3:          return $urandom;
      4, 5:          return 32'd1 << $urandom_range(0, 31);
      6, 7:          return (32'd1 << $urandom_range(0, 31)) - 32'd1;
      8, 9, 10, 11:  return $urandom_range(0, 4096);
      default:       return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_min();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_align();
    logic [DATA_W-1:0] lg;
    lg = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    return ($urandom & ~32'h1F) | lg;
  endfunction

  function automatic logic [DATA_W-1:0] pick_rounds();
    logic [DATA_W-1:0] rr;
    case ($urandom_range(0, 9))
      0:       rr = 0;
      1:       rr = 32;
      2:       rr = $urandom_range(33, 63);
      default: rr = $urandom_range(1, 4);
    endcase
    return ($urandom & ~32'h3F) | rr;
  endfunction

  initial begin
    int unsigned ph, k, idle_pct;
    logic        act;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    start <= 1'b0;
    action_i <= ACTION_ALLOC;
    request_size_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, bump, alignment, second chunk
    issue(ACTION_ALLOC, 32'd0);
    issue(ACTION_ALLOC, 32'd100);
    issue(ACTION_ALLOC, 32'd1);
    issue(ACTION_ADVANCE, 32'hFFFF_FFFF);
    issue(ACTION_ALLOC, 32'h0030_0000);
    hold_off(3);
    issue(ACTION_ALLOC, 32'h0010_0000);

    // min zero, alignment above the cap, rounds zero, capacity saturation
    drain();
    program_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    issue(ACTION_ALLOC, 32'hFFFF_FFFF);
    issue(ACTION_ALLOC, 32'd5);
    issue(ACTION_ADVANCE, 32'd0);
    issue(ACTION_ALLOC, 32'h0020_0000);

    // largest min chunk, no alignment, rounds of 32, fill the table
    drain();
    program_regs(32'hFFFF_FFFF, 32'd0, 32'd32, 1'b1);
    issue(ACTION_ALLOC, 32'd1);
    for (k = 0; k < 6; k++) issue(ACTION_ALLOC, 32'h8000_0000);
    issue(ACTION_ADVANCE, 32'd0);
    issue(ACTION_ALLOC, 32'hFFFF_FFFF);
    issue(ACTION_ALLOC, 32'd0);

    // smallest min chunk, largest alignment, recycle every frame
    drain();
    program_regs(32'd1, 32'd16, 32'd1, 1'b0);
    issue(ACTION_ADVANCE, 32'h5555_AAAA);
    issue(ACTION_ALLOC, 32'h0001_0001);
    issue(ACTION_ALLOC, 32'hFFFF_FFFF);
    issue(ACTION_ALLOC, 32'h0000_FFFF);

    // random phases, each under its own register setting
    for (ph = 0; ph < 8; ph++) begin
      drain();
      program_regs(pick_min(), pick_align(), pick_rounds(), ph == 3);
      idle_pct = (ph % 2 == 0) ? 35 : 8;
      for (k = 0; k < 100; k++) begin
        act = ($urandom_range(0, 99) < 20) ? ACTION_ADVANCE : ACTION_ALLOC;
        issue(act, pick_size());
        if (n_sent < 720 && $urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 10));
      end
    end

    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d requests (%0d opened a chunk, %0d met a full table), %0d advances",
             ledger.n_alloc, ledger.n_opened, ledger.n_full, ledger.n_adv);
    $display("under %0d register settings", n_settings);
    if (ledger.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
